@@ hdl/stp_pkg.sv @@
// Shared types, constants and codes of the scope trace plotter.
`default_nettype none
package stp_pkg;

    localparam int DEF_SCREEN_COLUMNS = 128;
    localparam int DEF_CHANNELS       = 5;
    localparam int MAX_CHANNELS       = 5;

    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 16;
    localparam int ROW_W    = 7;
    localparam int X_W      = 8;
    localparam int CH_W     = 3;

    localparam int ZERO_ROW  = 61;
    localparam int HALF_SPAN = 60;

    // Quotient |s|*60/d stays at or below 60 once |s| is clamped to d.
    localparam int QUOT_BITS = 6;
    localparam int NUM_W     = $clog2((1 << (SAMPLE_W - 1)) * HALF_SPAN + 1);
    localparam int CNT_W     = $clog2(QUOT_BITS);

    localparam logic [1:0] CFG_CHANNEL_ENABLE = 2'd0;
    localparam logic [1:0] CFG_AUTO_SCALE     = 2'd1;
    localparam logic [1:0] CFG_RUN            = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [1:0] {
        KIND_ERASE = 2'd0,
        KIND_GRID  = 2'd1,
        KIND_TRACE = 2'd2
    } draw_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_CLAMP,
        LN_DIV,
        LN_WRITE,
        LN_DONE
    } lane_state_t;

    typedef struct packed {
        logic start;
        logic auto_scale;
        logic wrapped;
    } lane_ctrl_t;

    typedef struct packed {
        logic [ROW_W-1:0] old_row;
        logic [ROW_W-1:0] new_row;
    } lane_res_t;

endpackage
`default_nettype wire

@@ hdl/stp_lane.sv @@
// One channel lane: peak tracking, clamp, restoring divider and row store.
`default_nettype none
module stp_lane #(
    parameter int SCREEN_COLUMNS = stp_pkg::DEF_SCREEN_COLUMNS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire stp_pkg::lane_ctrl_t               ctrl,
    input  wire logic [$clog2(SCREEN_COLUMNS)-1:0] col,
    input  wire logic                              enable,
    input  wire stp_pkg::sample_t                  sample,
    output logic                                   done,
    output stp_pkg::lane_res_t                     res
);
    import stp_pkg::*;

    lane_state_t state_reg, state_next;

    logic [PEAK_W-1:0]    peak_reg;
    logic [PEAK_W-1:0]    mag_reg;
    logic                 neg_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [NUM_W-1:0]     dsh_reg;
    logic [QUOT_BITS-1:0] q_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [ROW_W-1:0]     old_reg;
    logic                 old_ok_reg;
    logic [ROW_W-1:0]     new_reg;
    logic [ROW_W-1:0]     row_mem [SCREEN_COLUMNS];

    sample_t           s_in;
    logic [PEAK_W:0]   s_ext;
    logic [PEAK_W:0]   mag_full;
    logic [PEAK_W-1:0] mag_in;
    logic [PEAK_W-1:0] mag_clamp;
    logic [PEAK_W-1:0] divisor;
    logic [ROW_W-1:0]  row_val;

    always_comb
    begin
        s_in      = enable ? sample : '0;
        s_ext     = {s_in[SAMPLE_W-1], s_in};
        mag_full  = s_in[SAMPLE_W-1] ? (~s_ext + 1'b1) : s_ext;
        mag_in    = mag_full[PEAK_W-1:0];
        // Symmetric clamp: the magnitude saturates at the peak, the sign stays.
        mag_clamp = (mag_reg > peak_reg) ? peak_reg : mag_reg;
        divisor   = (peak_reg == '0) ? PEAK_W'(1) : peak_reg;
        row_val   = neg_reg ? (ROW_W'(ZERO_ROW) + ROW_W'(q_reg))
                            : (ROW_W'(ZERO_ROW) - ROW_W'(q_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LN_IDLE, LN_DONE:
            begin
                if (ctrl.start)
                begin
                    state_next = LN_CLAMP;
                end
            end
            LN_CLAMP:
            begin
                state_next = LN_DIV;
            end
            LN_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = LN_WRITE;
                end
            end
            LN_WRITE:
            begin
                state_next = LN_DONE;
            end
            default:
            begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
            peak_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.start && ctrl.auto_scale && (mag_in > peak_reg))
            begin
                peak_reg <= mag_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mag_reg    <= mag_in;
            neg_reg    <= s_in[SAMPLE_W-1];
            old_reg    <= row_mem[col];
            old_ok_reg <= ctrl.wrapped;
        end
        case (state_reg)
            LN_CLAMP:
            begin
                num_reg <= NUM_W'(mag_clamp) * NUM_W'(HALF_SPAN);
                dsh_reg <= NUM_W'(divisor) << (QUOT_BITS - 1);
                q_reg   <= '0;
                cnt_reg <= CNT_W'(QUOT_BITS - 1);
            end
            LN_DIV:
            begin
                // One restoring step: subtract the shifted divisor when it fits.
                if (num_reg >= dsh_reg)
                begin
                    num_reg <= num_reg - dsh_reg;
                    q_reg   <= {q_reg[QUOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[QUOT_BITS-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            LN_WRITE:
            begin
                row_mem[col] <= row_val;
                new_reg      <= row_val;
            end
            default:
            begin
            end
        endcase
    end

    assign done        = (state_reg == LN_DONE);
    assign res.old_row = old_ok_reg ? old_reg : '0;
    assign res.new_row = new_reg;

endmodule
`default_nettype wire

@@ hdl/stp_merge.sv @@
// Merge stage: walks the lanes in channel order and issues draw commands.
`default_nettype none
module stp_merge #(
    parameter int CHANNELS = stp_pkg::DEF_CHANNELS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [stp_pkg::X_W-1:0]       x,
    input  wire stp_pkg::lane_res_t            res [stp_pkg::MAX_CHANNELS],
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic [stp_pkg::X_W-1:0]            pixel_x,
    output logic [stp_pkg::ROW_W-1:0]          pixel_y,
    output stp_pkg::draw_kind_t                draw_kind,
    output logic [stp_pkg::CH_W-1:0]           channel,
    output logic                               last,
    output logic                               finished
);
    import stp_pkg::*;

    logic             active_reg;
    logic [CH_W-1:0]  ch_reg;
    logic             phase_reg;
    logic             out_valid_reg;
    logic [X_W-1:0]   px_reg;
    logic [ROW_W-1:0] py_reg;
    draw_kind_t       kind_reg;
    logic [CH_W-1:0]  chan_reg;
    logic             last_reg;

    lane_res_t        cur;
    logic             adv;
    logic             has_old;
    logic             is_last;
    logic             load;

    always_comb
    begin
        cur     = res[ch_reg];
        adv     = active_reg && (!out_valid_reg || !out_stall);
        // Restore the dashed zero line only on its lit columns.
        has_old = ((cur.old_row != '0) && (cur.old_row != ROW_W'(ZERO_ROW)))
               || ((cur.old_row == ROW_W'(ZERO_ROW)) && !x[1]);
        is_last = phase_reg && (ch_reg == CH_W'(CHANNELS - 1));
        load    = adv && (phase_reg || has_old);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            ch_reg        <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (start)
            begin
                active_reg <= 1'b1;
                ch_reg     <= '0;
                phase_reg  <= 1'b0;
            end
            else if (adv)
            begin
                if (phase_reg)
                begin
                    if (is_last)
                    begin
                        active_reg <= 1'b0;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 1'b1;
                        phase_reg <= 1'b0;
                    end
                end
                else
                begin
                    phase_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg   <= x;
            chan_reg <= ch_reg;
            last_reg <= is_last;
            if (phase_reg)
            begin
                py_reg   <= cur.new_row;
                kind_reg <= KIND_TRACE;
            end
            else
            begin
                py_reg   <= cur.old_row;
                kind_reg <= (cur.old_row == ROW_W'(ZERO_ROW)) ? KIND_GRID : KIND_ERASE;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign draw_kind = kind_reg;
    assign channel   = chan_reg;
    assign last      = last_reg;
    assign finished  = adv && is_last;

endmodule
`default_nettype wire

@@ hdl/scope_trace_plotter_top.sv @@
// From accept to the first draw transfer: clamp, six divider steps, writeback, merge
// handoff; the merge then takes an old-pixel phase and a trace phase for each channel.
// A new item is not taken until the merge has finished with the last one (in_stall is
// high outside idle), and an output stall holds the merge.
// Reset clears configuration to its defaults, the column pointer and each peak; the
// row store is not swept: columns read as empty until the ring has wrapped once.
`default_nettype none
module scope_trace_plotter_top #(
    parameter int SCREEN_COLUMNS = stp_pkg::DEF_SCREEN_COLUMNS,
    parameter int CHANNELS       = stp_pkg::DEF_CHANNELS
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [4:0]               cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire stp_pkg::sample_t         sample_0,
    input  wire stp_pkg::sample_t         sample_1,
    input  wire stp_pkg::sample_t         sample_2,
    input  wire stp_pkg::sample_t         sample_3,
    input  wire stp_pkg::sample_t         sample_4,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [stp_pkg::X_W-1:0]       pixel_x,
    output logic [stp_pkg::ROW_W-1:0]     pixel_y,
    output stp_pkg::draw_kind_t           draw_kind,
    output logic [stp_pkg::CH_W-1:0]      channel,
    output logic                          last
);
    import stp_pkg::*;

    localparam int COL_W = $clog2(SCREEN_COLUMNS);

    logic [MAX_CHANNELS-1:0] chan_en_reg;
    logic                    auto_reg;
    logic                    run_reg;
    logic [COL_W-1:0]        col_reg;
    logic                    wrapped_reg;
    ctl_state_t              state_reg, state_next;

    sample_t                 smp [MAX_CHANNELS];
    lane_res_t               res_arr [MAX_CHANNELS];
    logic [CHANNELS-1:0]     lane_done;
    lane_ctrl_t              lane_ctrl;
    logic                    accept;
    logic                    merge_start;
    logic                    finished;
    logic                    col_adv;

    assign smp[0] = sample_0;
    assign smp[1] = sample_1;
    assign smp[2] = sample_2;
    assign smp[3] = sample_3;
    assign smp[4] = sample_4;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next           = state_reg;
        lane_ctrl.start      = 1'b0;
        lane_ctrl.auto_scale = auto_reg;
        lane_ctrl.wrapped    = wrapped_reg;
        merge_start          = 1'b0;
        col_adv              = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Drop items while stopped.
                if (accept && run_reg)
                begin
                    lane_ctrl.start = 1'b1;
                    state_next      = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (&lane_done)
                begin
                    merge_start = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (finished)
                begin
                    col_adv    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            chan_en_reg <= MAX_CHANNELS'(1);
            auto_reg    <= 1'b1;
            run_reg     <= 1'b1;
            col_reg     <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CHANNEL_ENABLE: chan_en_reg <= cfg_data[MAX_CHANNELS-1:0];
                    CFG_AUTO_SCALE:     auto_reg    <= cfg_data[0];
                    CFG_RUN:            run_reg     <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (col_adv)
            begin
                if (col_reg == COL_W'(SCREEN_COLUMNS - 1))
                begin
                    col_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    for (genvar c = 0; c < MAX_CHANNELS; c++)
    begin : g_lane
        if (c < CHANNELS)
        begin : g_on
            stp_lane #(
                .SCREEN_COLUMNS(SCREEN_COLUMNS)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (lane_ctrl),
                .col    (col_reg),
                .enable (chan_en_reg[c]),
                .sample (smp[c]),
                .done   (lane_done[c]),
                .res    (res_arr[c])
            );
        end
        else
        begin : g_off
            assign res_arr[c] = '0;
        end
    end

    stp_merge #(
        .CHANNELS(CHANNELS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (merge_start),
        .x         (X_W'(col_reg) + 1'b1),
        .res       (res_arr),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .draw_kind (draw_kind),
        .channel   (channel),
        .last      (last),
        .finished  (finished)
    );

endmodule
`default_nettype wire
